// ----- rtl/sttf_pkg.sv -----
// ----------------------------------------------------------------------------
// sttf_pkg
// Shared types and constants of the silence trim with fade block.
// ----------------------------------------------------------------------------
package sttf_pkg;

    // payload widths
    localparam int FRAME_W   = 16;
    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int RAMP_W    = 16;
    localparam int CHUSE_W   = 4;

    // item operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LEN      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_USED = 1'b1;

    // reset values of the registers
    localparam logic [RAMP_W-1:0]  RAMP_LEN_RST      = 16'd441;
    localparam logic [CHUSE_W-1:0] CHANNELS_USED_RST = 4'd1;

    // Q0.16 fixed point: one, and three for the smoothstep polynomial
    localparam logic [16:0] Q_ONE   = 17'h10000;
    localparam logic [17:0] Q_THREE = 18'd196608;
    // bias for divide by 2^17 rounding toward zero
    localparam logic signed [33:0] HALF_DIV_BIAS = 34'sd131071;

    localparam int DIV_BITS_PER_CYCLE = 4;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_RDCHK = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_SQ    = 9'b000010000,
        S_CUBE  = 9'b000100000,
        S_GAIN  = 9'b001000000,
        S_SCALE = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

endpackage

// ----- rtl/sttf_in_if.sv -----
// ----------------------------------------------------------------------------
// sttf_in_if
// Input item channel: load or read request.
// ----------------------------------------------------------------------------
interface sttf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 op;
    logic [sttf_pkg::FRAME_W-1:0]         frame;
    logic [sttf_pkg::CHAN_W-1:0]          channel;
    logic signed [sttf_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, op, frame, channel, sample, input ready);
    modport sink   (input valid, op, frame, channel, sample, output ready);
endinterface

// ----- rtl/sttf_out_if.sv -----
// ----------------------------------------------------------------------------
// sttf_out_if
// Result item channel: faded sample and crop status.
// ----------------------------------------------------------------------------
interface sttf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sttf_pkg::SAMPLE_W-1:0] value;
    logic [sttf_pkg::LEN_W-1:0]           cropped_length;
    logic [sttf_pkg::FRAME_W-1:0]         first_frame;
    logic                                 empty_res;
    logic                                 out_of_range;

    modport source (output valid, value, cropped_length, first_frame, empty_res,
                    out_of_range, input ready);
    modport sink   (input valid, value, cropped_length, first_frame, empty_res,
                    out_of_range, output ready);
endinterface

// ----- rtl/silence_trim_with_fade.sv -----
// ----------------------------------------------------------------------------
// silence_trim_with_fade
// Sample store with nonzero-crop tracking and smoothstep fade-in/fade-out reads.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  -------   ---  ---------------  ----------------------------------------------
//  i_in      in   valid/ready      op, frame, channel, sample
//  o_out     out  valid/ready      value, cropped_length, first_frame,
//                                  empty_res, out_of_range
//  cfg       in   i_cfg_we         i_cfg_idx, i_cfg_wdata (ramp_len, channels_used)
//
//  One item at a time. A load goes from accept through the load state to the
//  result register; a read inside the crop passes crop check and store read,
//  the radix-16 ramp divider, then four multiply stages (square, cube term,
//  gain product, sample scale). Reads outside the crop skip divider and multiplies.
//  Synchronous active-low reset clears the FSM, the crop tracker and the
//  config registers; the sample store has no reset and needs no clearing pass.
//  A finished result waits in the output register; the next item is accepted
//  meanwhile and its own result holds in the last state until the register frees.
//
module silence_trim_with_fade #(
    parameter int unsigned MAX_FRAMES   = 65536,
    parameter int unsigned MAX_CHANNELS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sttf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sttf_pkg::CFG_DAT_W-1:0]        i_cfg_wdata,
    sttf_in_if.sink                               i_in,
    sttf_out_if.source                            o_out
);

    localparam int unsigned DEPTH = MAX_FRAMES * MAX_CHANNELS;
    localparam int          AW    = $clog2(DEPTH);

    // restoring divider state: remainder stays below the divisor unless the ramp saturates
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] q;
    } t_div;

    // four quotient bits per call
    function automatic t_div div_step(t_div cur, logic [15:0] den);
        t_div        nx;
        logic [16:0] sh;
        nx = cur;
        for (int k = 0; k < sttf_pkg::DIV_BITS_PER_CYCLE; k++) begin
            sh = {nx.rem, 1'b0};
            if (sh >= {1'b0, den}) begin
                nx.rem = 16'(sh - {1'b0, den});
                nx.q   = {nx.q[14:0], 1'b1};
            end else begin
                nx.rem = sh[15:0];
                nx.q   = {nx.q[14:0], 1'b0};
            end
        end
        return nx;
    endfunction

    // ---------------- config ----------------
    logic [sttf_pkg::RAMP_W-1:0]  r_ramp_len;
    logic [sttf_pkg::CHUSE_W-1:0] r_channels_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_len      <= sttf_pkg::RAMP_LEN_RST;
            r_channels_used <= sttf_pkg::CHANNELS_USED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sttf_pkg::REG_RAMP_LEN:      r_ramp_len      <= i_cfg_wdata;
                sttf_pkg::REG_CHANNELS_USED: r_channels_used <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // zero ramp acts as one; channel count clamps to [1, MAX_CHANNELS]
    logic [15:0] ramp_eff;
    logic [4:0]  ch_eff;
    assign ramp_eff = (r_ramp_len == '0) ? 16'd1 : r_ramp_len;

    always_comb begin
        if (r_channels_used == '0) begin
            ch_eff = 5'd1;
        end else if ({1'b0, r_channels_used} > 5'(MAX_CHANNELS)) begin
            ch_eff = 5'(MAX_CHANNELS);
        end else begin
            ch_eff = {1'b0, r_channels_used};
        end
    end

    // ---------------- state ----------------
    sttf_pkg::t_state r_state, n_state;

    logic               r_op;
    logic [15:0]        r_frame;
    logic [2:0]         r_channel;
    logic signed [15:0] r_sample;

    logic               r_seen;
    logic [15:0]        r_first;
    logic [15:0]        r_last;

    logic [1:0]         r_div_cnt;
    t_div               r_div_a, r_div_b;
    logic               r_sat_a, r_sat_b;
    logic [16:0]        r_r2_a, r_r2_b;
    logic [17:0]        r_t_a, r_t_b;
    logic [16:0]        r_s_a, r_s_b;
    logic [16:0]        r_gain;
    logic signed [33:0] r_prod;
    logic               r_oor;

    logic               r_out_valid;
    logic signed [15:0] r_o_value;
    logic [16:0]        r_o_len;
    logic [15:0]        r_o_first;
    logic               r_o_empty;
    logic               r_o_oor;

    // ---------------- datapath helpers ----------------
    logic        chan_ok, frame_ok;
    logic [16:0] crop_len;
    logic [16:0] frame_abs;
    logic [31:0] lin_addr;
    logic [AW-1:0] addr;
    logic        mem_we, mem_re;
    logic [15:0] dist_b;
    logic [16:0] ra, rb;
    logic        out_free;
    logic signed [33:0] rounded;

    assign chan_ok  = {2'b0, r_channel} < ch_eff;
    assign frame_ok = 32'(r_frame) < 32'(MAX_FRAMES);
    assign crop_len = r_seen ? 17'({1'b0, r_last} - {1'b0, r_first} + 17'd1) : 17'd0;
    // distance from the last cropped frame: len - 1 - offset
    assign dist_b   = 16'(r_last - r_first - r_frame);

    assign frame_abs = (r_state == sttf_pkg::S_LOAD) ? {1'b0, r_frame}
                                                     : {1'b0, r_first} + {1'b0, r_frame};
    assign lin_addr  = 32'(frame_abs) * 32'(MAX_CHANNELS) + 32'(r_channel);
    assign addr      = lin_addr[AW-1:0];

    assign mem_we = (r_state == sttf_pkg::S_LOAD) && chan_ok && frame_ok;
    assign mem_re = (r_state == sttf_pkg::S_RDCHK);

    assign ra = r_sat_a ? sttf_pkg::Q_ONE : {1'b0, r_div_a.q};
    assign rb = r_sat_b ? sttf_pkg::Q_ONE : {1'b0, r_div_b.q};

    assign out_free = !r_out_valid || o_out.ready;
    // truncate toward zero on the divide by 2^17 (includes the 0.5 factor)
    assign rounded  = (r_prod + (r_prod[33] ? sttf_pkg::HALF_DIV_BIAS : 34'sd0)) >>> 17;

    // ---------------- sample store ----------------
    logic [15:0]        r_store [0:DEPTH-1];
    logic signed [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[addr] <= r_sample;
        end
        if (mem_re) begin
            r_rd_data <= r_store[addr];
        end
    end

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sttf_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.op == sttf_pkg::OP_READ) ? sttf_pkg::S_RDCHK
                                                             : sttf_pkg::S_LOAD;
                end
            end
            sttf_pkg::S_LOAD:  n_state = sttf_pkg::S_DONE;
            sttf_pkg::S_RDCHK: begin
                if (!r_seen || (17'(r_frame) >= crop_len) || !chan_ok) begin
                    n_state = sttf_pkg::S_DONE;
                end else begin
                    n_state = sttf_pkg::S_DIV;
                end
            end
            sttf_pkg::S_DIV: begin
                if (r_div_cnt == 2'd3) begin
                    n_state = sttf_pkg::S_SQ;
                end
            end
            sttf_pkg::S_SQ:    n_state = sttf_pkg::S_CUBE;
            sttf_pkg::S_CUBE:  n_state = sttf_pkg::S_GAIN;
            sttf_pkg::S_GAIN:  n_state = sttf_pkg::S_SCALE;
            sttf_pkg::S_SCALE: n_state = sttf_pkg::S_DONE;
            sttf_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = sttf_pkg::S_IDLE;
                end
            end
            default: n_state = sttf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sttf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // crop tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
        end else if (mem_we && (r_sample != '0)) begin
            if (!r_seen) begin
                r_seen  <= 1'b1;
                r_first <= r_frame;
                r_last  <= r_frame;
            end else begin
                if (r_frame < r_first) begin
                    r_first <= r_frame;
                end
                if (r_frame > r_last) begin
                    r_last <= r_frame;
                end
            end
        end
    end

    // item capture and arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else begin
            unique case (r_state)
                sttf_pkg::S_IDLE: begin
                    if (i_in.valid) begin
                        r_op      <= i_in.op;
                        r_frame   <= i_in.frame;
                        r_channel <= i_in.channel;
                        r_sample  <= i_in.sample;
                    end
                end
                sttf_pkg::S_LOAD: begin
                    r_prod <= '0;
                    r_oor  <= 1'b0;
                end
                sttf_pkg::S_RDCHK: begin
                    r_prod    <= '0;
                    r_oor     <= r_seen && ((17'(r_frame) >= crop_len) || !chan_ok);
                    r_div_cnt <= '0;
                    // distance >= ramp saturates the ramp at one
                    r_sat_a   <= r_frame >= ramp_eff;
                    r_sat_b   <= dist_b >= ramp_eff;
                    r_div_a   <= '{rem: r_frame, q: '0};
                    r_div_b   <= '{rem: dist_b, q: '0};
                end
                sttf_pkg::S_DIV: begin
                    r_div_cnt <= r_div_cnt + 2'd1;
                    r_div_a   <= div_step(r_div_a, ramp_eff);
                    r_div_b   <= div_step(r_div_b, ramp_eff);
                end
                sttf_pkg::S_SQ: begin
                    r_r2_a <= 17'((34'(ra) * 34'(ra)) >> 16);
                    r_r2_b <= 17'((34'(rb) * 34'(rb)) >> 16);
                    r_t_a  <= sttf_pkg::Q_THREE - {ra, 1'b0};
                    r_t_b  <= sttf_pkg::Q_THREE - {rb, 1'b0};
                end
                sttf_pkg::S_CUBE: begin
                    r_s_a <= 17'((35'(r_r2_a) * 35'(r_t_a)) >> 16);
                    r_s_b <= 17'((35'(r_r2_b) * 35'(r_t_b)) >> 16);
                end
                sttf_pkg::S_GAIN: begin
                    r_gain <= 17'((34'(r_s_a) * 34'(r_s_b)) >> 16);
                end
                sttf_pkg::S_SCALE: begin
                    r_prod <= 34'(r_rd_data) * 34'(signed'({1'b0, r_gain}));
                end
                sttf_pkg::S_DONE: ;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == sttf_pkg::S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
            r_o_value   <= rounded[15:0];
            r_o_len     <= crop_len;
            r_o_first   <= r_seen ? r_first : 16'd0;
            r_o_empty   <= !r_seen;
            r_o_oor     <= (r_op == sttf_pkg::OP_READ) && r_oor;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready           = (r_state == sttf_pkg::S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_o_value;
    assign o_out.cropped_length = r_o_len;
    assign o_out.first_frame    = r_o_first;
    assign o_out.empty_res      = r_o_empty;
    assign o_out.out_of_range   = r_o_oor;

    // ---------------- assertions ----------------
    a_crop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_first <= r_last))
        else $error("crop bounds out of order");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.empty_res) |->
            (o_out.cropped_length == '0 && o_out.value == '0 && !o_out.out_of_range))
        else $error("empty result carries data");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_of_range) |-> (o_out.value == '0))
        else $error("out of range read gave nonzero value");

    a_value_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.value <= 16'sd16384) && (o_out.value >= -16'sd16384)))
        else $error("faded value exceeds half scale");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sttf_pkg::S_DIV) |=>
            ((r_state == sttf_pkg::S_DIV) || ($past(r_div_cnt) == 2'd3)))
        else $error("divider left early");

endmodule

// ----- test/silence_trim_with_fade_test.sv -----
// ----------------------------------------------------------------------------
// silence_trim_with_fade_test
// Self-checking bench: loads and reads against a cycle-free crop/fade predictor.
// Directed edge cases first, then random phases across register settings,
// with random stalls on both channels and a quiet final stretch.
// ----------------------------------------------------------------------------
module silence_trim_with_fade_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    // worst quiet stretch: a send gap, a read and a result stall,
    // plus the settle pause around register writes; taken many times over
    localparam int STUCK_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int CROP_BASE     = 900;   // random loads land near here so the
    localparam int CROP_SPAN     = 200;   // crop stays short and the fades show

    typedef struct packed {
        logic signed [sttf_pkg::SAMPLE_W-1:0] value;
        logic [sttf_pkg::LEN_W-1:0]           cropped_length;
        logic [sttf_pkg::FRAME_W-1:0]         first_frame;
        logic                                 empty_res;
        logic                                 out_of_range;
    } t_crop_result;

    // ------------------------------------------------------------------------
    // Crop tracker, sample store and fade math, plus the queue of results
    // still owed by the block.
    // ------------------------------------------------------------------------
    class crop_scoreboard;
        int unsigned  ramp_len   = sttf_pkg::RAMP_LEN_RST;
        int unsigned  chans_used = sttf_pkg::CHANNELS_USED_RST;
        int unsigned  first_nz;
        int unsigned  last_nz;
        bit           seen_nz;
        shortint      samples[int];     // key: frame * 8 + channel
        int           written_keys[$];
        t_crop_result owed_q[$];
        int unsigned  n_loads, n_ignored, n_reads_in, n_reads_out, n_reads_empty;
        int unsigned  n_checked, n_errors;

        function void set_register(logic [sttf_pkg::CFG_IDX_W-1:0] idx,
                                   logic [sttf_pkg::CFG_DAT_W-1:0] data);
            if (idx == sttf_pkg::REG_RAMP_LEN) begin
                ramp_len = data[sttf_pkg::RAMP_W-1:0];
            end else if (idx == sttf_pkg::REG_CHANNELS_USED) begin
                chans_used = data[sttf_pkg::CHUSE_W-1:0];
            end
        endfunction

        function int unsigned active_chans();
            if (chans_used == 0) return 1;
            if (chans_used > 8) return 8;
            return chans_used;
        endfunction

        function int unsigned crop_length();
            return seen_nz ? last_nz - first_nz + 1 : 0;
        endfunction

        // smoothstep 3r^2 - 2r^3 of r = min(1, gap / ramp), Q0.16
        function longint unsigned smoothstep_q16(int unsigned gap);
            longint unsigned span, d64, ramp_pos, sq;
            span = (ramp_len == 0) ? 1 : ramp_len;
            d64 = gap;
            ramp_pos = (d64 << 16) / span;
            if (ramp_pos > sttf_pkg::Q_ONE) ramp_pos = sttf_pkg::Q_ONE;
            sq = (ramp_pos * ramp_pos) >> 16;
            return (sq * (sttf_pkg::Q_THREE - 2 * ramp_pos)) >> 16;
        endfunction

        function void note_item(sttf_pkg::t_op op, logic [sttf_pkg::FRAME_W-1:0] frame,
                                logic [sttf_pkg::CHAN_W-1:0] chan,
                                logic signed [sttf_pkg::SAMPLE_W-1:0] smp);
            t_crop_result want;
            int unsigned  nch, len, f, c;
            int           k;
            longint       stored, gain, scaled;
            want = '0;
            nch = active_chans();
            f = frame;
            c = chan;
            if (op == sttf_pkg::OP_LOAD) begin
                n_loads++;
                if (c < nch) begin
                    k = f * 8 + c;
                    if (!samples.exists(k)) written_keys.push_back(k);
                    samples[k] = smp;
                    // zero loads never move the crop, even over a nonzero entry
                    if (smp != 0) begin
                        if (!seen_nz) begin
                            first_nz = f;
                            last_nz  = f;
                            seen_nz  = 1'b1;
                        end else begin
                            if (f < first_nz) first_nz = f;
                            if (f > last_nz)  last_nz  = f;
                        end
                    end
                end else begin
                    n_ignored++;
                end
            end
            len = crop_length();
            if (op == sttf_pkg::OP_READ) begin
                if (!seen_nz) begin
                    n_reads_empty++;
                end else if (f >= len || c >= nch) begin
                    n_reads_out++;
                    want.out_of_range = 1'b1;
                end else begin
                    n_reads_in++;
                    k = (first_nz + f) * 8 + c;
                    stored = samples.exists(k) ? samples[k] : 0;
                    gain = longint'((smoothstep_q16(f) * smoothstep_q16(len - 1 - f)) >> 16);
                    // the 0.5 factor is folded into the 2^17 divide, toward zero
                    scaled = (stored * gain) / 131072;
                    want.value = sttf_pkg::SAMPLE_W'(scaled);
                end
            end
            want.cropped_length = sttf_pkg::LEN_W'(len);
            want.first_frame    = seen_nz ? sttf_pkg::FRAME_W'(first_nz) : '0;
            want.empty_res      = !seen_nz;
            owed_q.push_back(want);
        endfunction

        function void compare_field(string name, logic signed [17:0] want,
                                    logic signed [17:0] got);
            if (got !== want) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_crop_result got);
            t_crop_result want;
            n_checked++;
            if (owed_q.size() == 0) begin
                n_errors++;
                $display("%0t: result with none owed, expected nothing actual value %0d",
                         $time, got.value);
                return;
            end
            want = owed_q.pop_front();
            compare_field("value",          want.value,          got.value);
            compare_field("cropped_length", want.cropped_length, got.cropped_length);
            compare_field("first_frame",    want.first_frame,    got.first_frame);
            compare_field("empty_res",      want.empty_res,      got.empty_res);
            compare_field("out_of_range",   want.out_of_range,   got.out_of_range);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its channels
    // ------------------------------------------------------------------------
    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sttf_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [sttf_pkg::CFG_DAT_W-1:0] cfg_wdata;

    sttf_in_if  in_if ();
    sttf_out_if out_if ();

    silence_trim_with_fade u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    crop_scoreboard sb;
    int unsigned    send_idle_pct;
    int unsigned    sink_idle_pct;
    bit             calm;           // final stretch: no idling on either side
    int unsigned    stall_left;
    int unsigned    stuck;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Result side backpressure: random stall bursts, none in the final stretch.
    always @(negedge clk) begin
        if (calm) begin
            stall_left    <= 0;
            out_if.ready  <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            out_if.ready  <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            stall_left    <= $urandom_range(0, 10);
            out_if.ready  <= 1'b0;
        end else begin
            out_if.ready  <= 1'b1;
        end
    end

    // Every accepted result goes straight to the scoreboard.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(t_crop_result'{out_if.value, out_if.cropped_length,
                                           out_if.first_frame, out_if.empty_res,
                                           out_if.out_of_range});
        end
    end

    // Watchdog: cycles in a row with no item moving on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        wait (stuck >= STUCK_LIMIT);
        $display("%0t: no progress for %0d cycles, %0d results still owed",
                 $time, STUCK_LIMIT, sb.owed_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input sttf_pkg::t_op op,
                             input logic [sttf_pkg::FRAME_W-1:0] frame,
                             input logic [sttf_pkg::CHAN_W-1:0] chan,
                             input logic signed [sttf_pkg::SAMPLE_W-1:0] smp);
        if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.op      <= op;
        in_if.frame   <= frame;
        in_if.channel <= chan;
        in_if.sample  <= smp;
        do @(posedge clk); while (!in_if.ready);
        sb.note_item(op, frame, chan, smp);
        @(negedge clk);
    endtask

    // Block idle: nothing owed, then a pause for the last result to retire.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input int unsigned ramp, input int unsigned chans);
        cfg_we    <= 1'b1;
        cfg_idx   <= sttf_pkg::REG_RAMP_LEN;
        cfg_wdata <= sttf_pkg::CFG_DAT_W'(ramp);
        sb.set_register(sttf_pkg::REG_RAMP_LEN, sttf_pkg::CFG_DAT_W'(ramp));
        @(negedge clk);
        cfg_idx   <= sttf_pkg::REG_CHANNELS_USED;
        cfg_wdata <= sttf_pkg::CFG_DAT_W'(chans);
        sb.set_register(sttf_pkg::REG_CHANNELS_USED, sttf_pkg::CFG_DAT_W'(chans));
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Read address: mostly a written entry inside the crop, else noise.
    // Never lands on a store entry that was never written.
    function automatic void pick_read(output logic [sttf_pkg::FRAME_W-1:0] f,
                                      output logic [sttf_pkg::CHAN_W-1:0] c);
        int unsigned len, nch, kind, tries;
        int          k;
        bit          hit;
        len  = sb.crop_length();
        nch  = sb.active_chans();
        kind = $urandom_range(0, 9);
        f    = sttf_pkg::FRAME_W'($urandom);
        c    = sttf_pkg::CHAN_W'($urandom);
        hit  = 1'b0;
        if (kind == 1) begin
            f = sttf_pkg::FRAME_W'(len + $urandom_range(0, 3));   // just past the crop
        end else if (kind >= 2 && sb.written_keys.size() != 0) begin
            for (tries = 0; tries < 16 && !hit; tries++) begin
                k = sb.written_keys[$urandom_range(0, sb.written_keys.size() - 1)];
                if ((k >> 3) >= sb.first_nz && (k >> 3) <= sb.last_nz && (k & 7) < nch) begin
                    f   = sttf_pkg::FRAME_W'((k >> 3) - sb.first_nz);
                    c   = sttf_pkg::CHAN_W'(k & 7);
                    hit = 1'b1;
                end
            end
        end
        if (sb.seen_nz && f < len && c < nch
                && !sb.samples.exists(int'((sb.first_nz + f) * 8 + c))) begin
            if (len <= 16'hFFFF) begin
                f = sttf_pkg::FRAME_W'(len);
            end else if (nch < 8) begin
                c = sttf_pkg::CHAN_W'(nch);
            end else begin
                // full-width crop: every written entry lies inside it
                k = sb.written_keys[$urandom_range(0, sb.written_keys.size() - 1)];
                f = sttf_pkg::FRAME_W'((k >> 3) - sb.first_nz);
                c = sttf_pkg::CHAN_W'(k & 7);
            end
        end
    endfunction

    // wide: loads may hit any frame with any sample (crop already full width)
    task automatic random_item(input bit wide);
        logic [sttf_pkg::FRAME_W-1:0]         f;
        logic [sttf_pkg::CHAN_W-1:0]          c;
        logic signed [sttf_pkg::SAMPLE_W-1:0] s;
        int unsigned                          nch;
        nch = sb.active_chans();
        if ($urandom_range(0, 99) < 45) begin
            c = ($urandom_range(0, 4) != 0) ? sttf_pkg::CHAN_W'($urandom_range(0, nch - 1))
                                            : sttf_pkg::CHAN_W'($urandom);
            s = ($urandom_range(0, 7) == 0) ? '0 : sttf_pkg::SAMPLE_W'($urandom);
            if (wide) begin
                f = sttf_pkg::FRAME_W'($urandom);
            end else if ($urandom_range(0, 15) == 0) begin
                // far away and silent: fills the store, leaves the crop alone
                f = sttf_pkg::FRAME_W'($urandom);
                s = '0;
            end else begin
                f = sttf_pkg::FRAME_W'(CROP_BASE + $urandom_range(0, CROP_SPAN));
            end
            send_item(sttf_pkg::OP_LOAD, f, c, s);
        end else begin
            pick_read(f, c);
            send_item(sttf_pkg::OP_READ, f, c, sttf_pkg::SAMPLE_W'($urandom));
        end
    endtask

    task automatic run_phase(input int unsigned ramp, input int unsigned chans,
                             input int unsigned count, input int unsigned s_pct,
                             input int unsigned r_pct);
        settle();
        write_config(ramp, chans);
        send_idle_pct = s_pct;
        sink_idle_pct = r_pct;
        repeat (count) random_item(1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = sttf_pkg::REG_RAMP_LEN;
        cfg_wdata     = '0;
        in_if.valid   = 1'b0;
        in_if.op      = sttf_pkg::OP_LOAD;
        in_if.frame   = '0;
        in_if.channel = '0;
        in_if.sample  = '0;
        out_if.ready  = 1'b0;
        stall_left    = 0;
        send_idle_pct = 20;
        sink_idle_pct = 20;
        calm          = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, at reset register values (ramp 441, one channel).
        // Empty store: reads answer empty, silent loads keep it empty.
        send_item(sttf_pkg::OP_READ, 16'hFFFF, 3'd7, 16'sh7FFF);
        send_item(sttf_pkg::OP_READ, 16'h0000, 3'd0, 16'sh0000);
        send_item(sttf_pkg::OP_LOAD, 16'h0000, 3'd0, 16'sh0000);
        send_item(sttf_pkg::OP_LOAD, 16'hFFFF, 3'd0, 16'sh0000);
        // channel beyond the active count: load dropped
        send_item(sttf_pkg::OP_LOAD, 16'd2000, 3'd7, 16'sh1234);
        send_item(sttf_pkg::OP_READ, 16'h0000, 3'd0, 16'sh0000);
        // first nonzero, then out-of-order loads stretch both ends
        send_item(sttf_pkg::OP_LOAD, 16'd1000, 3'd0, -16'sd32768);
        send_item(sttf_pkg::OP_LOAD, 16'd1004, 3'd0, 16'sd32767);
        send_item(sttf_pkg::OP_LOAD, 16'd998,  3'd0, 16'sd12345);
        send_item(sttf_pkg::OP_LOAD, 16'd999,  3'd0, 16'sd32767);
        send_item(sttf_pkg::OP_LOAD, 16'd1001, 3'd0, -16'sd1);
        send_item(sttf_pkg::OP_LOAD, 16'd1002, 3'd0, -16'sd32768);
        send_item(sttf_pkg::OP_LOAD, 16'd1003, 3'd0, 16'sd1);
        // crop is 998..1004: edges, middle, just past the end, far out, bad channel
        send_item(sttf_pkg::OP_READ, 16'd0,    3'd0, 16'sh0000);
        send_item(sttf_pkg::OP_READ, 16'd3,    3'd0, 16'sh0000);
        send_item(sttf_pkg::OP_READ, 16'd6,    3'd0, 16'sh0000);
        send_item(sttf_pkg::OP_READ, 16'd7,    3'd0, 16'sh0000);
        send_item(sttf_pkg::OP_READ, 16'hFFFF, 3'd0, 16'shFFFF);
        send_item(sttf_pkg::OP_READ, 16'd2,    3'd7, 16'sh0000);
        // silence over the last nonzero frame: crop stays, sample reads zero
        send_item(sttf_pkg::OP_LOAD, 16'd1004, 3'd0, 16'sh0000);
        send_item(sttf_pkg::OP_READ, 16'd6,    3'd0, 16'sh0000);

        // Random phases over register settings, extremes included:
        // ramp zero acts as one, channel count zero acts as one, 15 clips to 8.
        run_phase(20,    2,  90, 20, 20);
        run_phase(7,     8, 100, 25, 25);
        run_phase(0,    15, 100,  0,  0);
        run_phase(65535, 0,  90, 30, 10);
        run_phase(1,     3, 100, 10, 40);
        run_phase(40,    8, 100, 20, 20);
        run_phase($urandom_range(1, 300), $urandom_range(1, 8), 100, 15, 15);

        // Final stretch, no idling: open the crop to the full frame range.
        settle();
        write_config(441, 8);
        calm = 1'b1;
        send_item(sttf_pkg::OP_LOAD, 16'h0000, 3'd0, 16'sd1);
        send_item(sttf_pkg::OP_LOAD, 16'hFFFF, 3'd7, -16'sd1);
        send_item(sttf_pkg::OP_READ, 16'h0000, 3'd0, 16'sh0000);
        send_item(sttf_pkg::OP_READ, 16'hFFFF, 3'd7, 16'sh0000);
        repeat (106) random_item(1'b1);

        settle();
        $display("covered %0d loads (%0d dropped), %0d reads in the crop, %0d outside, %0d empty",
                 sb.n_loads, sb.n_ignored, sb.n_reads_in, sb.n_reads_out, sb.n_reads_empty);
        $display("%0d results checked across all register phases, %0d mismatches",
                 sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
